@@ rtl/svpc_pkg.sv @@
package svpc_pkg;

	localparam int ID_BUF_BYTES_DEF = 64;
	localparam int NUM_BITS_DEF     = 32;

	// Result field widths on the output beat
	localparam int OUT_NUM_W = 32;
	localparam int OUT_LEN_W = 6;
	localparam int ORD_W     = 2;
	localparam int RES_BITS  = 3 * OUT_NUM_W + 2 * OUT_LEN_W + ORD_W;
	localparam int DATA_W    = ((RES_BITS + 7) / 8) * 8;

	typedef logic signed [ORD_W-1:0] ord_t;

	localparam ord_t ORD_LT = 2'sb11;
	localparam ord_t ORD_EQ = 2'sb00;
	localparam ord_t ORD_GT = 2'sb01;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	typedef struct packed {
		logic                 valid;
		logic [OUT_NUM_W-1:0] major;
		logic [OUT_NUM_W-1:0] minor;
		logic [OUT_NUM_W-1:0] patch;
		logic [OUT_LEN_W-1:0] pre_len;
		logic [OUT_LEN_W-1:0] meta_len;
		ord_t                 order;
	} result_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return (c inside {["A":"Z"], ["a":"z"], ["0":"9"]}) || (c == CH_MINUS);
	endfunction

endpackage

@@ rtl/svpc_text_mem.sv @@
module svpc_text_mem #(
	parameter int ID_BUF_BYTES = svpc_pkg::ID_BUF_BYTES_DEF,
	localparam int CNT_W = $clog2(ID_BUF_BYTES)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic             wr_bank,
	input  logic [CNT_W-1:0] wr_idx,
	input  logic [7:0]       wr_data,
	input  logic             rd_bank,
	input  logic [CNT_W-1:0] rd_idx,
	output logic [7:0]       rd_data_q
);
	import svpc_pkg::*;

	// Two banks: one holds the last valid prerelease, the other takes the new one
	logic [7:0] mem_q [2][ID_BUF_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_bank][wr_idx] <= wr_data;
		end
		// Forward a byte written to the very entry being read
		if (wr_en && wr_bank == rd_bank && wr_idx == rd_idx) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem_q[rd_bank][rd_idx];
		end
	end

endmodule

@@ rtl/svpc_parser.sv @@
module svpc_parser #(
	parameter int ID_BUF_BYTES = svpc_pkg::ID_BUF_BYTES_DEF,
	parameter int NUM_BITS     = svpc_pkg::NUM_BITS_DEF,
	localparam int CNT_W = $clog2(ID_BUF_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       ch,
	input  logic             last,
	input  logic [7:0]       prev_byte,
	output logic             wr_en,
	output logic             wr_bank,
	output logic [CNT_W-1:0] wr_idx,
	output logic [7:0]       wr_data,
	output logic             rd_bank,
	output logic [CNT_W-1:0] rd_idx,
	output logic             res_valid,
	output svpc_pkg::result_t res
);
	import svpc_pkg::*;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(ID_BUF_BYTES - 1);

	typedef enum logic [2:0] {
		PH_MAJ, PH_MIN, PH_PAT, PH_PRE, PH_META, PH_DONE, PH_ERR
	} phase_t;

	typedef enum logic [2:0] {
		NS_START, NS_WS, NS_SIGN_BARE, NS_SIGN_WS, NS_DIG
	} nsub_t;

	phase_t                phase_q, phase_d;
	nsub_t                 nsub_q, nsub_d;
	logic [NUM_BITS-1:0]   acc_q, acc_d;
	logic                  sat_q, sat_d;
	logic                  neg_q, neg_d;
	logic [NUM_BITS-1:0]   maj_q, maj_d, min_q, min_d, pat_q, pat_d;
	ord_t                  maj_cmp_q, maj_cmp_d, min_cmp_q, min_cmp_d, pat_cmp_q, pat_cmp_d;
	ord_t                  pre_diff_q, pre_diff_d;
	logic                  ident_q, ident_d;
	logic [CNT_W-1:0]      pre_cnt_q, pre_cnt_d, meta_cnt_q, meta_cnt_d;
	logic [NUM_BITS-1:0]   prev_maj_q, prev_maj_d, prev_min_q, prev_min_d;
	logic [NUM_BITS-1:0]   prev_pat_q, prev_pat_d;
	logic [CNT_W-1:0]      prev_len_q, prev_len_d;
	logic                  bank_q, bank_d;
	logic                  fin, do_id;
	logic [NUM_BITS+3:0]   acc_ext, acc_x10;
	logic [NUM_BITS-1:0]   num_now;
	ord_t                  len_cmp;
	logic [CNT_W+OUT_LEN_W-1:0] pre_len_ext, meta_len_ext;

	function automatic logic [NUM_BITS-1:0] num_val(input logic [NUM_BITS-1:0] a,
			input logic s, input logic n);
		logic [NUM_BITS-1:0] v;
		if (s) v = '1;
		else if (n) v = -a;
		else v = a;
		return v;
	endfunction

	function automatic ord_t cmp_num(input logic [NUM_BITS-1:0] a, input logic [NUM_BITS-1:0] b);
		ord_t o;
		if (a < b) o = ORD_LT;
		else if (a > b) o = ORD_GT;
		else o = ORD_EQ;
		return o;
	endfunction

	function automatic logic [OUT_NUM_W-1:0] to_out(input logic [NUM_BITS-1:0] v);
		logic [NUM_BITS+OUT_NUM_W-1:0] t;
		t = {{OUT_NUM_W{1'b0}}, v};
		return t[OUT_NUM_W-1:0];
	endfunction

	// Decimal accumulate: acc * 10 + digit, with headroom to spot overflow
	assign acc_ext = {4'b0000, acc_q};
	assign acc_x10 = (acc_ext << 3) + (acc_ext << 1) + (NUM_BITS+4)'(ch[3:0]);
	assign num_now = num_val(acc_q, sat_q, neg_q);

	always_comb begin
		phase_d    = phase_q;
		nsub_d     = nsub_q;
		acc_d      = acc_q;
		sat_d      = sat_q;
		neg_d      = neg_q;
		maj_d      = maj_q;
		min_d      = min_q;
		pat_d      = pat_q;
		maj_cmp_d  = maj_cmp_q;
		min_cmp_d  = min_cmp_q;
		pat_cmp_d  = pat_cmp_q;
		pre_diff_d = pre_diff_q;
		ident_d    = ident_q;
		pre_cnt_d  = pre_cnt_q;
		meta_cnt_d = meta_cnt_q;
		prev_maj_d = prev_maj_q;
		prev_min_d = prev_min_q;
		prev_pat_d = prev_pat_q;
		prev_len_d = prev_len_q;
		bank_d     = bank_q;
		wr_en      = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		fin        = 1'b0;
		do_id      = 1'b0;
		len_cmp    = ORD_EQ;
		pre_len_ext  = '0;
		meta_len_ext = '0;

		if (step) begin
			if (phase_q != PH_DONE && phase_q != PH_ERR) begin
				if (ch == CH_NUL) begin
					fin = 1'b1;
				end else if (phase_q == PH_MAJ || phase_q == PH_MIN || phase_q == PH_PAT) begin
					if (is_digit(ch)) begin
						if (!sat_q) begin
							if (acc_x10[NUM_BITS+3:NUM_BITS] != 4'b0000) sat_d = 1'b1;
							else acc_d = acc_x10[NUM_BITS-1:0];
						end
						nsub_d = NS_DIG;
					end else if ((nsub_q == NS_START || nsub_q == NS_WS) && is_ws(ch)) begin
						nsub_d = NS_WS;
					end else if ((nsub_q == NS_START || nsub_q == NS_WS) &&
							(ch == CH_PLUS || ch == CH_MINUS)) begin
						neg_d  = (ch == CH_MINUS);
						nsub_d = (nsub_q == NS_START) ? NS_SIGN_BARE : NS_SIGN_WS;
					end else if (nsub_q == NS_DIG || nsub_q == NS_START) begin
						if (phase_q == PH_MAJ || phase_q == PH_MIN) begin
							if (ch != CH_DOT) begin
								phase_d = PH_ERR;
							end else begin
								if (phase_q == PH_MAJ) begin
									maj_d     = num_now;
									maj_cmp_d = cmp_num(num_now, prev_maj_q);
									phase_d   = PH_MIN;
								end else begin
									min_d     = num_now;
									min_cmp_d = cmp_num(num_now, prev_min_q);
									phase_d   = PH_PAT;
								end
								acc_d  = '0;
								sat_d  = 1'b0;
								neg_d  = 1'b0;
								nsub_d = NS_START;
							end
						end else begin
							pat_d     = num_now;
							pat_cmp_d = cmp_num(num_now, prev_pat_q);
							ident_d   = 1'b0;
							if (ch == CH_MINUS) phase_d = PH_PRE;
							else if (ch == CH_PLUS) phase_d = PH_META;
							else phase_d = PH_ERR;
						end
					end else if (phase_q == PH_PAT && nsub_q == NS_SIGN_BARE) begin
						// Bare sign after minor: it opens prerelease or metadata
						pat_d     = '0;
						pat_cmp_d = cmp_num('0, prev_pat_q);
						phase_d   = neg_q ? PH_PRE : PH_META;
						ident_d   = 1'b0;
						do_id     = 1'b1;
					end else begin
						phase_d = PH_ERR;
					end
				end else begin
					do_id = 1'b1;
				end

				if (do_id) begin
					if (is_ident(ch) || ch == CH_DOT) begin
						if (ch == CH_DOT && !ident_d) begin
							phase_d = PH_ERR;
						end else begin
							ident_d = (ch != CH_DOT);
							if (phase_d == PH_PRE) begin
								if (pre_cnt_q != CAP) begin
									wr_en     = 1'b1;
									pre_cnt_d = pre_cnt_q + 1'b1;
									if (pre_diff_q == ORD_EQ && pre_cnt_q < prev_len_q) begin
										if (ch < prev_byte) pre_diff_d = ORD_LT;
										else if (ch > prev_byte) pre_diff_d = ORD_GT;
									end
								end
							end else if (meta_cnt_q != CAP) begin
								meta_cnt_d = meta_cnt_q + 1'b1;
							end
						end
					end else if (ch == CH_PLUS && phase_d == PH_PRE) begin
						if (!ident_d) begin
							phase_d = PH_ERR;
						end else begin
							phase_d = PH_META;
							ident_d = 1'b0;
						end
					end else begin
						phase_d = PH_ERR;
					end
				end
			end

			if (last) fin = 1'b1;

			if (fin) begin
				case (phase_d)
					PH_PAT: begin
						if (nsub_d == NS_DIG || nsub_d == NS_START) begin
							pat_d     = num_val(acc_d, sat_d, neg_d);
							pat_cmp_d = cmp_num(num_val(acc_d, sat_d, neg_d), prev_pat_q);
							phase_d   = PH_DONE;
						end else begin
							phase_d = PH_ERR;
						end
					end
					PH_PRE, PH_META: begin
						phase_d = ident_d ? PH_DONE : PH_ERR;
					end
					PH_DONE: begin
						phase_d = PH_DONE;
					end
					default: begin
						phase_d = PH_ERR;
					end
				endcase
			end

			if (last) begin
				res_valid = 1'b1;
				if (phase_d == PH_DONE) begin
					if (pre_cnt_d < prev_len_q) len_cmp = ORD_LT;
					else if (pre_cnt_d > prev_len_q) len_cmp = ORD_GT;
					pre_len_ext  = {{OUT_LEN_W{1'b0}}, pre_cnt_d};
					meta_len_ext = {{OUT_LEN_W{1'b0}}, meta_cnt_d};
					res.valid    = 1'b1;
					res.major    = to_out(maj_d);
					res.minor    = to_out(min_d);
					res.patch    = to_out(pat_d);
					res.pre_len  = pre_len_ext[OUT_LEN_W-1:0];
					res.meta_len = meta_len_ext[OUT_LEN_W-1:0];
					if (maj_cmp_d != ORD_EQ) res.order = maj_cmp_d;
					else if (min_cmp_d != ORD_EQ) res.order = min_cmp_d;
					else if (pat_cmp_d != ORD_EQ) res.order = pat_cmp_d;
					else if (pre_diff_d != ORD_EQ) res.order = pre_diff_d;
					else res.order = len_cmp;
					// This version becomes the reference; swap text banks
					prev_maj_d = maj_d;
					prev_min_d = min_d;
					prev_pat_d = pat_d;
					prev_len_d = pre_cnt_d;
					bank_d     = ~bank_q;
				end
				phase_d    = PH_MAJ;
				nsub_d     = NS_START;
				acc_d      = '0;
				sat_d      = 1'b0;
				neg_d      = 1'b0;
				maj_d      = '0;
				min_d      = '0;
				pat_d      = '0;
				maj_cmp_d  = ORD_EQ;
				min_cmp_d  = ORD_EQ;
				pat_cmp_d  = ORD_EQ;
				pre_diff_d = ORD_EQ;
				ident_d    = 1'b0;
				pre_cnt_d  = '0;
				meta_cnt_d = '0;
			end
		end
	end

	assign wr_bank = ~bank_q;
	assign wr_idx  = pre_cnt_q;
	assign wr_data = ch;
	// Prefetch the reference byte that the next prerelease byte meets
	assign rd_bank = bank_d;
	assign rd_idx  = pre_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MAJ;
			nsub_q     <= NS_START;
			acc_q      <= '0;
			sat_q      <= 1'b0;
			neg_q      <= 1'b0;
			maj_q      <= '0;
			min_q      <= '0;
			pat_q      <= '0;
			maj_cmp_q  <= ORD_EQ;
			min_cmp_q  <= ORD_EQ;
			pat_cmp_q  <= ORD_EQ;
			pre_diff_q <= ORD_EQ;
			ident_q    <= 1'b0;
			pre_cnt_q  <= '0;
			meta_cnt_q <= '0;
			prev_maj_q <= '0;
			prev_min_q <= '0;
			prev_pat_q <= '0;
			prev_len_q <= '0;
			bank_q     <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			nsub_q     <= nsub_d;
			acc_q      <= acc_d;
			sat_q      <= sat_d;
			neg_q      <= neg_d;
			maj_q      <= maj_d;
			min_q      <= min_d;
			pat_q      <= pat_d;
			maj_cmp_q  <= maj_cmp_d;
			min_cmp_q  <= min_cmp_d;
			pat_cmp_q  <= pat_cmp_d;
			pre_diff_q <= pre_diff_d;
			ident_q    <= ident_d;
			pre_cnt_q  <= pre_cnt_d;
			meta_cnt_q <= meta_cnt_d;
			prev_maj_q <= prev_maj_d;
			prev_min_q <= prev_min_d;
			prev_pat_q <= prev_pat_d;
			prev_len_q <= prev_len_d;
			bank_q     <= bank_d;
		end
	end

endmodule

@@ rtl/semver_string_parse_compare.sv @@
// Semantic version parser and comparator.
//
// Input stream: one character of a version string per beat on s_tdata, with
// s_tlast on the final character. A NUL character ends the string early; the
// characters after it up to the s_tlast beat are dropped.
// Output stream: one result beat per string, m_tuser high when the string is a
// well formed MAJOR.MINOR.PATCH[-pre][+meta]. The beat carries the numbers, the
// stored prerelease and metadata lengths, and the order against the last valid
// version (-1 older, 0 equal, 1 newer). An invalid string gives all zeros.
//
// Path: the s_tlast beat is registered in s1 and, once the result slot is free, its
// result is registered in the output register and presented as the result beat.
// Throughput: one character per cycle outside stalls, back to back, across string
// borders; each character updates the parse state in the single stage behind the
// input register, and the prerelease text store is read one entry ahead of need.
// Stall: a finished result waits in the output register; characters keep
// flowing until the next s_tlast beat, which is held in s1 until the pending
// result is taken.
// Reset: the parse restarts and the reference version becomes 0.0.0 with no
// prerelease. The text store needs no clearing.
module semver_string_parse_compare #(
	parameter int ID_BUF_BYTES = svpc_pkg::ID_BUF_BYTES_DEF,
	parameter int NUM_BITS     = svpc_pkg::NUM_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] ch
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [31:0] major, [63:32] minor, [95:64] patch, [101:96] pre_len,
	// [107:102] meta_len, [109:108] order, rest zero
	output logic [svpc_pkg::DATA_W-1:0] m_tdata,
	output logic                        m_tuser   // [0] valid_res
);
	import svpc_pkg::*;

	localparam int CNT_W = $clog2(ID_BUF_BYTES);

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;
	logic             step;
	logic             wr_en;
	logic             wr_bank;
	logic [CNT_W-1:0] wr_idx;
	logic [7:0]       wr_data;
	logic             rd_bank;
	logic [CNT_W-1:0] rd_idx;
	logic [7:0]       prev_byte;
	logic             res_valid;
	result_t          res;
	logic             valid_s2;
	result_t          res_s2;

	// Advance s1 unless it holds a final character and the result slot is full and not being taken
	assign step     = valid_s1 && !(last_s1 && valid_s2 && !m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	svpc_parser #(
		.ID_BUF_BYTES(ID_BUF_BYTES),
		.NUM_BITS    (NUM_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.ch       (ch_s1),
		.last     (last_s1),
		.prev_byte(prev_byte),
		.wr_en    (wr_en),
		.wr_bank  (wr_bank),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data),
		.rd_bank  (rd_bank),
		.rd_idx   (rd_idx),
		.res_valid(res_valid),
		.res      (res)
	);

	svpc_text_mem #(
		.ID_BUF_BYTES(ID_BUF_BYTES)
	) u_text_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_bank  (wr_bank),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data),
		.rd_bank  (rd_bank),
		.rd_idx   (rd_idx),
		.rd_data_q(prev_byte)
	);

	// Result register: load a new result, drop it once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.valid;
	assign m_tdata  = {{(DATA_W - RES_BITS){1'b0}}, res_s2.order, res_s2.meta_len,
		res_s2.pre_len, res_s2.patch, res_s2.minor, res_s2.major};

endmodule

@@ rtl/svpc_checker.sv @@
module svpc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        s_tlast,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [svpc_pkg::DATA_W-1:0] m_tdata,
	input logic                        m_tuser
);
	import svpc_pkg::*;

	localparam int ORD_LSB = 3 * OUT_NUM_W + 2 * OUT_LEN_W;

	// A held result beat keeps its content
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// An invalid version reports nothing but zeros
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invalid result carries nonzero fields");

	// Order is one of older, equal, newer
	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ORD_LSB +: ORD_W] != 2'b10)
		else $error("order field out of range");

	// The input side only backs off behind a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a pending result");

	// A final beat that leaves s1 at once shows up as a result beat
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast ##1 s_tready |=> m_tvalid)
		else $error("final beat gave no result beat");

endmodule

bind semver_string_parse_compare svpc_checker u_svpc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
